/* sv/gdda_pkg.sv */
// shared constants, command and status types for the grid dda ray caster
// used by every module of the block but gdda_ram; depends on nothing
`timescale 1ns / 1ps

package gdda_pkg;

	localparam int MAP_SIZE       = 32;
	localparam int MAP_BITS       = 5;
	localparam int MAP_DEPTH      = MAP_SIZE * MAP_SIZE;
	localparam int ADDR_W         = 2 * MAP_BITS;
	localparam int SCREEN_COLUMNS = 800;
	localparam int SCREEN_ROWS    = 600;
	localparam int HALF_ROWS      = SCREEN_ROWS / 2;
	localparam int FRAC_BITS      = 16;
	localparam int GUARD_STEPS    = 2 * MAP_SIZE + 8;
	localparam int GUARD_W        = $clog2(GUARD_STEPS + 1);
	localparam int COORD_W        = MAP_BITS + 2;
	localparam int DIV_W          = 33;
	localparam int DEN_W          = 32;
	localparam int DIV_CNT_W      = $clog2(DIV_W + 1);
	localparam int SD_W           = 41;
	localparam int CODE_W         = 4;
	localparam int CFG_W          = 21;

	// column * 2^17 / SCREEN_COLUMNS as (column * CAM_RECIP) >> CAM_SHIFT,
	// exact over the valid columns
	localparam int          CAM_SHIFT = 15;
	localparam logic [31:0] CAM_RECIP =
		32'(((64'd1 << 32) + 64'(SCREEN_COLUMNS) - 64'd1) / 64'(SCREEN_COLUMNS));

	localparam logic [2:0] CFG_POS_X   = 3'd0;
	localparam logic [2:0] CFG_POS_Y   = 3'd1;
	localparam logic [2:0] CFG_DIR_X   = 3'd2;
	localparam logic [2:0] CFG_DIR_Y   = 3'd3;
	localparam logic [2:0] CFG_PLANE_X = 3'd4;
	localparam logic [2:0] CFG_PLANE_Y = 3'd5;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_WRITE,
		OP_LOAD,
		OP_RAY_MUL,
		OP_RAY_SUM,
		OP_DIV_X,
		OP_LATCH_DX,
		OP_DIV_Y,
		OP_LATCH_DY,
		OP_SIDE_MUL,
		OP_SIDE_SET,
		OP_STEP,
		OP_CHECK,
		OP_PERP,
		OP_DIV_H
	} op_t;

	typedef struct packed {
		op_t  op;
		logic final_out;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic is_write;
		logic cast_ok;
		logic div_done;
		logic out_map;
		logic hit;
		logic guard_end;
	} status_t;

endpackage

/* sv/gdda_ram.sv */
// generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps

module gdda_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/gdda_div.sv */
// restoring divider, one quotient bit per cycle
// depends on gdda_pkg; a zero divisor gives an all-ones quotient
`timescale 1ns / 1ps

module gdda_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [gdda_pkg::DIV_W-1:0] num,
	input  logic [gdda_pkg::DEN_W-1:0] den,
	output logic                      done,
	output logic [gdda_pkg::DIV_W-1:0] quo
);
	import gdda_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DEN_W:0]       trial;
	logic [DEN_W:0]       diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= DIV_CNT_W'(DIV_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* sv/gdda_datapath.sv */
// datapath: view registers, map ram, shared divider, ray setup, dda walk
// depends on gdda_pkg, gdda_ram and gdda_div
`timescale 1ns / 1ps

module gdda_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gdda_pkg::cmd_t       cmd,
	output gdda_pkg::status_t    status,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [gdda_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                 mode,
	input  logic [4:0]           cell_row,
	input  logic [4:0]           cell_col,
	input  logic [3:0]           cell_value,
	input  logic [9:0]           column,
	output logic                 done,
	output logic [9:0]           out_column,
	output logic                 side,
	output logic [3:0]           wall_code,
	output logic                 left_map,
	output logic [21:0]          perp_distance,
	output logic [15:0]          line_height,
	output logic [9:0]           draw_start,
	output logic [9:0]           draw_end
);
	import gdda_pkg::*;

	// view registers
	logic [20:0]        pos_x_q, pos_y_q;
	logic signed [17:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= 21'd1441792;
			pos_y_q   <= 21'd786432;
			dir_x_q   <= -18'sd65536;
			dir_y_q   <= '0;
			plane_x_q <= '0;
			plane_y_q <= 18'sd43254;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_POS_X:   pos_x_q   <= cfg_wdata;
				CFG_POS_Y:   pos_y_q   <= cfg_wdata;
				CFG_DIR_X:   dir_x_q   <= cfg_wdata[17:0];
				CFG_DIR_Y:   dir_y_q   <= cfg_wdata[17:0];
				CFG_PLANE_X: plane_x_q <= cfg_wdata[17:0];
				CFG_PLANE_Y: plane_y_q <= cfg_wdata[17:0];
				default: ;
			endcase
		end
	end

	// map ram and clearing pass
	logic [ADDR_W-1:0] clr_q;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [CODE_W-1:0] ram_wdata, ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.op == OP_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		if (cmd.op == OP_CLEAR) begin
			ram_we = 1'b1;
		end else if (cmd.op == OP_WRITE) begin
			ram_we    = (int'(cell_row) < MAP_SIZE) && (int'(cell_col) < MAP_SIZE);
			ram_waddr = {cell_row[MAP_BITS-1:0], cell_col[MAP_BITS-1:0]};
			ram_wdata = cell_value;
		end
	end

	gdda_ram #(.WIDTH(CODE_W), .DEPTH(MAP_DEPTH)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// shared divider
	logic             div_start, div_done;
	logic [DIV_W-1:0] div_num, div_quo;
	logic [DEN_W-1:0] div_den;

	logic signed [19:0] rx_q, ry_q;
	logic [21:0]        perp_q;
	logic [18:0]        mag_x, mag_y;

	assign mag_x = rx_q[19] ? 19'(-rx_q) : rx_q[18:0];
	assign mag_y = ry_q[19] ? 19'(-ry_q) : ry_q[18:0];

	always_comb begin
		div_start = 1'b0;
		div_num   = {1'b1, {(DIV_W-1){1'b0}}};
		div_den   = DEN_W'(mag_x);
		case (cmd.op)
			OP_DIV_X: begin
				div_start = 1'b1;
			end
			OP_DIV_Y: begin
				div_start = 1'b1;
				div_den   = DEN_W'(mag_y);
			end
			OP_DIV_H: begin
				div_start = 1'b1;
				div_num   = DIV_W'(SCREEN_ROWS) << FRAC_BITS;
				div_den   = DEN_W'(perp_q);
			end
			default: ;
		endcase
	end

	gdda_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// ray setup
	logic [31:0]        cam_mul;
	logic signed [17:0] cam, cam_q;
	logic signed [35:0] prod_x_s1, prod_y_s1;
	logic [9:0]         column_q;
	logic [31:0]        dx_q, dy_q;
	logic [31:0]        delta_sat;

	// camera offset by reciprocal multiplication
	assign cam_mul   = 32'(column) * CAM_RECIP;
	assign cam       = $signed({1'b0, cam_mul[CAM_SHIFT +: FRAC_BITS+1]}) - 18'sd65536;
	assign delta_sat = div_quo[DIV_W-1] ? '1 : div_quo[31:0];

	// walk state
	logic                      neg_x_q, neg_y_q;
	logic signed [COORD_W-1:0] mx_q, my_q, nmx, nmy;
	logic [16:0]               frac_x, frac_y;
	logic [48:0]               side_x_s1, side_y_s1;
	logic [SD_W-1:0]           sdx_q, sdy_q;
	logic [GUARD_W-1:0]        guard_q;
	logic                      side_q, left_q, xstep;
	logic [CODE_W-1:0]         code_q;
	logic [SD_W-1:0]           diff;

	assign frac_x = rx_q[19] ? {1'b0, pos_x_q[15:0]} : 17'h10000 - {1'b0, pos_x_q[15:0]};
	assign frac_y = ry_q[19] ? {1'b0, pos_y_q[15:0]} : 17'h10000 - {1'b0, pos_y_q[15:0]};

	assign xstep = sdx_q < sdy_q;
	assign nmx   = !xstep ? mx_q : (neg_x_q ? mx_q - 1'b1 : mx_q + 1'b1);
	assign nmy   = xstep ? my_q : (neg_y_q ? my_q - 1'b1 : my_q + 1'b1);
	assign ram_raddr = {nmx[MAP_BITS-1:0], nmy[MAP_BITS-1:0]};

	assign diff = side_q ? sdy_q - SD_W'(dy_q) : sdx_q - SD_W'(dx_q);

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				column_q <= column;
				cam_q    <= cam;
			end
			OP_RAY_MUL: begin
				prod_x_s1 <= plane_x_q * cam_q;
				prod_y_s1 <= plane_y_q * cam_q;
			end
			OP_RAY_SUM: begin
				rx_q <= 20'(dir_x_q) + prod_x_s1[35:16];
				ry_q <= 20'(dir_y_q) + prod_y_s1[35:16];
			end
			OP_LATCH_DX: dx_q <= delta_sat;
			OP_LATCH_DY: dy_q <= delta_sat;
			OP_SIDE_MUL: begin
				side_x_s1 <= frac_x * dx_q;
				side_y_s1 <= frac_y * dy_q;
				neg_x_q   <= rx_q[19];
				neg_y_q   <= ry_q[19];
				mx_q      <= $signed(COORD_W'(pos_x_q[20:16]));
				my_q      <= $signed(COORD_W'(pos_y_q[20:16]));
				guard_q   <= '0;
				side_q    <= 1'b0;
				left_q    <= 1'b0;
				code_q    <= '0;
			end
			OP_SIDE_SET: begin
				sdx_q <= SD_W'(side_x_s1[48:16]);
				sdy_q <= SD_W'(side_y_s1[48:16]);
			end
			OP_STEP: begin
				mx_q    <= nmx;
				my_q    <= nmy;
				side_q  <= !xstep;
				guard_q <= guard_q + 1'b1;
				if (xstep) begin
					sdx_q <= sdx_q + SD_W'(dx_q);
				end else begin
					sdy_q <= sdy_q + SD_W'(dy_q);
				end
			end
			OP_CHECK: begin
				if (status.out_map) begin
					left_q <= 1'b1;
				end else begin
					code_q <= ram_rdata;
				end
			end
			OP_PERP: perp_q <= (diff > SD_W'(22'h3FFFFF)) ? 22'h3FFFFF : diff[21:0];
			default: ;
		endcase
	end

	// final result
	logic [15:0] lh;
	logic [14:0] half;
	logic [15:0] de_sum;

	assign lh     = (div_quo > DIV_W'(16'hFFFF)) ? 16'hFFFF : div_quo[15:0];
	assign half   = lh[15:1];
	assign de_sum = 16'(half) + 16'(HALF_ROWS);

	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.final_out;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.final_out) begin
			out_column    <= column_q;
			side          <= side_q;
			wall_code     <= left_q ? '0 : code_q;
			left_map      <= left_q;
			perp_distance <= perp_q;
			line_height   <= lh;
			draw_start    <= (int'(half) >= HALF_ROWS) ? '0 : 10'(HALF_ROWS - int'(half));
			draw_end      <= (int'(de_sum) >= SCREEN_ROWS) ? 10'(SCREEN_ROWS - 1) : de_sum[9:0];
		end
	end

	assign done = done_q;

	// status to the controller
	assign status.clear_last = clr_q == ADDR_W'(MAP_DEPTH - 1);
	assign status.is_write   = !mode;
	assign status.cast_ok    = int'(column) < SCREEN_COLUMNS;
	assign status.div_done   = div_done;
	assign status.out_map    = mx_q[COORD_W-1] || my_q[COORD_W-1] ||
	                           (mx_q >= $signed(COORD_W'(MAP_SIZE))) ||
	                           (my_q >= $signed(COORD_W'(MAP_SIZE)));
	assign status.hit        = ram_rdata != '0;
	assign status.guard_end  = guard_q == GUARD_W'(GUARD_STEPS);

endmodule

/* sv/gdda_ctrl.sv */
// controller: sequences the clearing pass, cell writes and the cast of a column
// depends on gdda_pkg
`timescale 1ns / 1ps

module gdda_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  gdda_pkg::status_t status,
	output gdda_pkg::cmd_t    cmd
);
	import gdda_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RAY_MUL,
		S_RAY_SUM,
		S_DX_START,
		S_DX_WAIT,
		S_DY_START,
		S_DY_WAIT,
		S_SIDE_MUL,
		S_SIDE_SET,
		S_STEP,
		S_CHECK,
		S_PERP,
		S_LH_START,
		S_LH_WAIT
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd.op        = OP_NONE;
		cmd.final_out = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (status.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					if (status.is_write) begin
						cmd.op = OP_WRITE;
					end else if (status.cast_ok) begin
						cmd.op  = OP_LOAD;
						state_d = S_RAY_MUL;
					end
				end
			end
			S_RAY_MUL: begin
				cmd.op  = OP_RAY_MUL;
				state_d = S_RAY_SUM;
			end
			S_RAY_SUM: begin
				cmd.op  = OP_RAY_SUM;
				state_d = S_DX_START;
			end
			S_DX_START: begin
				cmd.op  = OP_DIV_X;
				state_d = S_DX_WAIT;
			end
			S_DX_WAIT: begin
				if (status.div_done) begin
					cmd.op  = OP_LATCH_DX;
					state_d = S_DY_START;
				end
			end
			S_DY_START: begin
				cmd.op  = OP_DIV_Y;
				state_d = S_DY_WAIT;
			end
			S_DY_WAIT: begin
				if (status.div_done) begin
					cmd.op  = OP_LATCH_DY;
					state_d = S_SIDE_MUL;
				end
			end
			S_SIDE_MUL: begin
				cmd.op  = OP_SIDE_MUL;
				state_d = S_SIDE_SET;
			end
			S_SIDE_SET: begin
				cmd.op  = OP_SIDE_SET;
				state_d = S_STEP;
			end
			S_STEP: begin
				cmd.op  = OP_STEP;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				cmd.op = OP_CHECK;
				// the map read for the new cell lands here
				if (status.out_map || status.hit || status.guard_end) begin
					state_d = S_PERP;
				end else begin
					state_d = S_STEP;
				end
			end
			S_PERP: begin
				cmd.op  = OP_PERP;
				state_d = S_LH_START;
			end
			S_LH_START: begin
				cmd.op  = OP_DIV_H;
				state_d = S_LH_WAIT;
			end
			S_LH_WAIT: begin
				if (status.div_done) begin
					cmd.final_out = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = state_q != S_IDLE;

endmodule

/* sv/grid_dda_ray_caster.sv */
// Grid ray caster. After reset the block sweeps its 1024-cell map to zero,
// one cell a cycle, and holds busy high until the sweep ends. A cell write
// leaves busy low, and so does a cast of a column of 800 or more, which gives
// no result. A cast walks one to 72 grid cells: three divisions on the shared
// one-bit-per-cycle divider set most of its time, and each walk step waits for
// the registered map read. The result shows for one cycle with done high and
// must be taken then; busy drops in that same cycle, so the next item can be
// taken while it shows.
// depends on gdda_pkg, gdda_ctrl and gdda_datapath
`timescale 1ns / 1ps

module grid_dda_ray_caster (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [gdda_pkg::CFG_W-1:0] cfg_wdata,
	input  logic        mode,
	input  logic [4:0]  cell_row,
	input  logic [4:0]  cell_col,
	input  logic [3:0]  cell_value,
	input  logic [9:0]  column,
	output logic        done,
	output logic [9:0]  out_column,
	output logic        side,
	output logic [3:0]  wall_code,
	output logic        left_map,
	output logic [21:0] perp_distance,
	output logic [15:0] line_height,
	output logic [9:0]  draw_start,
	output logic [9:0]  draw_end
);
	import gdda_pkg::*;

	cmd_t    cmd;
	status_t status;

	gdda_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	gdda_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.mode          (mode),
		.cell_row      (cell_row),
		.cell_col      (cell_col),
		.cell_value    (cell_value),
		.column        (column),
		.done          (done),
		.out_column    (out_column),
		.side          (side),
		.wall_code     (wall_code),
		.left_map      (left_map),
		.perp_distance (perp_distance),
		.line_height   (line_height),
		.draw_start    (draw_start),
		.draw_end      (draw_end)
	);

endmodule
